// File: rtl/hsl_pkg.sv
// Shared types, widths and constants for the HSL to RGB conversion pipeline.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package hsl_pkg;

	localparam int HUE_W      = 16;
	localparam int FRAC_W     = 13;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 3;

	// Hue wrap: bias by six full turns so that every hue becomes non-negative
	localparam int WRAP_W               = 17;
	localparam logic [WRAP_W-1:0] HUE_BIAS = 17'd34560;
	localparam int SIXTH                = 960;
	localparam int SIXTH_SHIFT          = 6;     // 960 = 15 << 6
	localparam int RECIP_15             = 4369;  // floor(2^16 / 15), may come out one low
	localparam int RECIP_15_W           = 13;
	localparam int RECIP_15_SHIFT       = 16;
	localparam int RECIP_6              = 43;    // exact floor(q / 6) for q up to 70
	localparam int RECIP_6_SHIFT        = 8;

	localparam int Q_W        = 7;
	localparam int R_W        = 10;
	localparam int K_W        = 11;
	localparam int SEC_W      = 3;

	localparam int FRAC_ONE   = 4096;
	localparam int FD_W       = 14;
	localparam int CNUM_W     = 28;
	localparam int LM_W       = 23;
	localparam int TERM_W     = 38;
	localparam int SUM_W      = 39;
	localparam int SCALED_W   = 44;
	localparam int SCALE_MUL  = 17;  // 255 / 15
	localparam int SCALE_SHIFT = 31; // 2^25 * 64
	localparam int CHAN_MAX   = 255;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} hsl_adv_t;

	typedef enum logic [SEC_W-1:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} hsl_sector_t;

	typedef enum logic [1:0] {
		TERM_C,
		TERM_X,
		TERM_ZERO
	} hsl_term_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} hsl_chan_t;

	// Which of chroma, secondary or nothing a channel takes in a sector
	function automatic hsl_term_t term_sel(input hsl_chan_t ch, input hsl_sector_t sector);
		hsl_term_t t;
		t = TERM_ZERO;
		unique case (ch)
			CH_RED: begin
				unique case (sector)
					SEC_RY, SEC_MR: t = TERM_C;
					SEC_YG, SEC_BM: t = TERM_X;
					default:        t = TERM_ZERO;
				endcase
			end
			CH_GREEN: begin
				unique case (sector)
					SEC_YG, SEC_GC: t = TERM_C;
					SEC_RY, SEC_CB: t = TERM_X;
					default:        t = TERM_ZERO;
				endcase
			end
			CH_BLUE: begin
				unique case (sector)
					SEC_CB, SEC_BM: t = TERM_C;
					SEC_GC, SEC_MR: t = TERM_X;
					default:        t = TERM_ZERO;
				endcase
			end
			default: t = TERM_ZERO;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// File: rtl/hsl_hue_unit.sv
// Hue path, stages 1 to 3: wrap the hue, split it into 60-degree sectors
// and form the secondary weight k = 960 - 2*tri. Depends on hsl_pkg.
`default_nettype none

module hsl_hue_unit (
	input  logic                                clk,
	input  hsl_pkg::hsl_adv_t                   adv,
	input  logic signed [hsl_pkg::HUE_W-1:0]    hue,
	output logic signed [hsl_pkg::K_W-1:0]      k_s3,
	output hsl_pkg::hsl_sector_t                sector_s3
);
	import hsl_pkg::*;

	localparam int V_W    = WRAP_W - SIXTH_SHIFT;
	localparam int PROD_W = V_W + RECIP_15_W;
	localparam int SP_W   = 12;

	logic [WRAP_W-1:0] wrap;
	logic [PROD_W-1:0] recip_prod;
	logic [WRAP_W-1:0] wrap_s1;
	logic [Q_W-1:0]    q0_s1;

	logic [WRAP_W-1:0] rem_full;
	logic [Q_W-1:0]    q_fix;
	logic [R_W-1:0]    rem_fix;
	logic [Q_W-1:0]    q_s2;
	logic [R_W-1:0]    r_s2;

	logic [R_W+1:0]    twice_r;
	logic signed [R_W+1:0] k_wide;
	logic [SP_W-1:0]   sec_prod;
	logic [Q_W-1:0]    sec_val;

	// Stage 1: bias and estimate the sixth index
	assign wrap       = WRAP_W'(hue) + HUE_BIAS;
	assign recip_prod = PROD_W'(wrap[WRAP_W-1:SIXTH_SHIFT]) * PROD_W'(RECIP_15);

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			wrap_s1 <= wrap;
			q0_s1   <= recip_prod[RECIP_15_SHIFT +: Q_W];
		end
	end

	// Stage 2: remainder, fix an estimate that came out one low
	always_comb begin
		rem_full = wrap_s1 - WRAP_W'(q0_s1) * WRAP_W'(SIXTH);
		if (rem_full >= WRAP_W'(SIXTH)) begin
			q_fix   = q0_s1 + Q_W'(1);
			rem_fix = R_W'(rem_full - WRAP_W'(SIXTH));
		end else begin
			q_fix   = q0_s1;
			rem_fix = R_W'(rem_full);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			q_s2 <= q_fix;
			r_s2 <= rem_fix;
		end
	end

	// Stage 3: triangle weight and sector within the turn
	always_comb begin
		twice_r = {1'b0, r_s2, 1'b0};
		if (q_s2[0]) begin
			k_wide = $signed((R_W+2)'(SIXTH) - twice_r);
		end else begin
			k_wide = $signed(twice_r - (R_W+2)'(SIXTH));
		end
		sec_prod = SP_W'(q_s2) * SP_W'(RECIP_6);
		sec_val  = q_s2 - Q_W'(sec_prod[SP_W-1:RECIP_6_SHIFT]) * Q_W'(6);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			k_s3      <= k_wide[K_W-1:0];
			sector_s3 <= hsl_sector_t'(sec_val[SEC_W-1:0]);
		end
	end

endmodule

`default_nettype wire

// File: rtl/hsl_chroma_unit.sv
// Chroma path, stages 1 to 3: chroma numerator (1 - |2l - 1|) * s over 2^24,
// with lightness carried alongside. Depends on hsl_pkg.
`default_nettype none

module hsl_chroma_unit (
	input  logic                                 clk,
	input  hsl_pkg::hsl_adv_t                    adv,
	input  logic [hsl_pkg::FRAC_W-1:0]           saturation,
	input  logic [hsl_pkg::FRAC_W-1:0]           lightness,
	output logic signed [hsl_pkg::CNUM_W-1:0]    cnum_s3,
	output logic [hsl_pkg::FRAC_W-1:0]           lit_s3
);
	import hsl_pkg::*;

	localparam int D_W = FRAC_W + 2;

	logic signed [D_W-1:0]    diff;
	logic signed [D_W-1:0]    abs_dev;
	logic signed [D_W-1:0]    fd;
	logic signed [FD_W-1:0]   fd_s1;
	logic [FRAC_W-1:0]        sat_s1;
	logic [FRAC_W-1:0]        lit_s1;
	logic signed [CNUM_W-1:0] cnum_s2;
	logic [FRAC_W-1:0]        lit_s2;

	always_comb begin
		diff    = $signed({1'b0, lightness, 1'b0}) - $signed(D_W'(FRAC_ONE));
		abs_dev = diff[D_W-1] ? -diff : diff;
		fd      = $signed(D_W'(FRAC_ONE)) - abs_dev;
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			fd_s1  <= fd[FD_W-1:0];
			sat_s1 <= saturation;
			lit_s1 <= lightness;
		end
		if (adv.s2) begin
			cnum_s2 <= CNUM_W'(fd_s1) * CNUM_W'($signed({1'b0, sat_s1}));
			lit_s2  <= lit_s1;
		end
		if (adv.s3) begin
			cnum_s3 <= cnum_s2;
			lit_s3  <= lit_s2;
		end
	end

endmodule

`default_nettype wire

// File: rtl/hsl_mix_unit.sv
// Channel mix, stages 4 to 6: weight chroma by sector, add the offset,
// scale by 255 over the common denominator and clamp. Depends on hsl_pkg.
`default_nettype none

module hsl_mix_unit (
	input  logic                                clk,
	input  hsl_pkg::hsl_adv_t                   adv,
	input  logic signed [hsl_pkg::CNUM_W-1:0]   cnum_s3,
	input  logic [hsl_pkg::FRAC_W-1:0]          lit_s3,
	input  logic signed [hsl_pkg::K_W-1:0]      k_s3,
	input  hsl_pkg::hsl_sector_t                sector_s3,
	output logic [hsl_pkg::CHAN_W-1:0]          red,
	output logic [hsl_pkg::CHAN_W-1:0]          green,
	output logic [hsl_pkg::CHAN_W-1:0]          blue
);
	import hsl_pkg::*;

	localparam int HI_W = SCALED_W - SCALE_SHIFT;
	localparam logic signed [TERM_W-1:0] SIXTH_T = TERM_W'(SIXTH);

	logic signed [TERM_W-1:0] px_s4;
	logic signed [TERM_W-1:0] pc_s4;
	logic [LM_W-1:0]          lm_s4;
	hsl_sector_t              sector_s4;
	logic signed [SUM_W-1:0]  offset;

	logic signed [SUM_W-1:0]  sum_s5 [NUM_CHAN];
	logic [CHAN_W-1:0]        chan_s6 [NUM_CHAN];

	// Stage 4: products
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			px_s4     <= TERM_W'(cnum_s3) * TERM_W'(k_s3);
			pc_s4     <= TERM_W'(cnum_s3) * SIXTH_T;
			lm_s4     <= LM_W'(lit_s3) * LM_W'(SIXTH);
			sector_s4 <= sector_s3;
		end
	end

	assign offset = $signed({{(SUM_W-LM_W-FRAC_W){1'b0}}, lm_s4, {FRAC_W{1'b0}}});

	for (genvar g = 0; g < NUM_CHAN; g++) begin : g_chan
		hsl_term_t                 sel;
		logic signed [TERM_W-1:0]  term;
		logic signed [SCALED_W-1:0] scaled;
		logic [HI_W-1:0]           hi;
		logic [CHAN_W-1:0]         chan_val;

		// Stage 5: pick the term and add the offset
		always_comb begin
			sel = term_sel(hsl_chan_t'(2'(g)), sector_s4);
			unique case (sel)
				TERM_C:  term = pc_s4;
				TERM_X:  term = px_s4;
				default: term = -pc_s4;
			endcase
		end

		always_ff @(posedge clk) begin
			if (adv.s5) begin
				sum_s5[g] <= SUM_W'(term) + offset;
			end
		end

		// Stage 6: times 17, drop the denominator, clamp
		always_comb begin
			scaled = SCALED_W'(sum_s5[g]) + (SCALED_W'(sum_s5[g]) <<< 4);
			hi     = scaled[SCALED_W-1:SCALE_SHIFT];
			if (scaled <= 0) begin
				chan_val = '0;
			end else if (hi > HI_W'(CHAN_MAX)) begin
				chan_val = CHAN_W'(CHAN_MAX);
			end else begin
				chan_val = hi[CHAN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv.s6) begin
				chan_s6[g] <= chan_val;
			end
		end
	end

	assign red   = chan_s6[CH_RED];
	assign green = chan_s6[CH_GREEN];
	assign blue  = chan_s6[CH_BLUE];

endmodule

`default_nettype wire

// File: rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter top level: pipeline control and stage wiring.
// Depends on hsl_pkg, hsl_hue_unit, hsl_chroma_unit and hsl_mix_unit.
//
// Usage:
//   Input channel (in_valid / in_stall) carries hue (signed, 1/16 degree),
//   saturation and lightness (unsigned, 4096 = 1.0). Output channel
//   (out_valid / out_stall) carries red, green and blue, 8 bits each.
//   A transfer happens at a rising edge with valid high and stall low.
//   Depth: six register stages. Throughput: one item per cycle while
//   out_stall is low. Each stage holds its own valid bit, so bubbles close
//   up and an item is taken in whenever some stage ahead can move, even
//   while a finished result waits at the output.
//   Stage 1 and 2 carry the hue reciprocal estimate and the chroma
//   multiply, stage 4 the 28x11 secondary multiply, stage 6 the scale/clamp.
//   Reset (arst_n low, asynchronous) empties every stage; out_valid drops.
//   When the receiver stalls, the result holds steady on the output, the
//   stages behind it fill up, and in_stall rises once all six are full.
`default_nettype none

module hsl_to_rgb_converter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [hsl_pkg::HUE_W-1:0]  hue,
	input  logic [hsl_pkg::FRAC_W-1:0]        saturation,
	input  logic [hsl_pkg::FRAC_W-1:0]        lightness,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [hsl_pkg::CHAN_W-1:0]        red,
	output logic [hsl_pkg::CHAN_W-1:0]        green,
	output logic [hsl_pkg::CHAN_W-1:0]        blue
);
	import hsl_pkg::*;

	hsl_adv_t adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic signed [K_W-1:0]    k_s3;
	hsl_sector_t              sector_s3;
	logic signed [CNUM_W-1:0] cnum_s3;
	logic [FRAC_W-1:0]        lit_s3;

	// A stage loads when it is empty or its content moves on
	always_comb begin
		adv.s6 = !valid_s6 || !out_stall;
		adv.s5 = !valid_s5 || adv.s6;
		adv.s4 = !valid_s4 || adv.s5;
		adv.s3 = !valid_s3 || adv.s4;
		adv.s2 = !valid_s2 || adv.s3;
		adv.s1 = !valid_s1 || adv.s2;
	end

	assign in_stall  = !adv.s1;
	assign out_valid = valid_s6;

	// Advance valid bits with their data; a held stage keeps its bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv.s1) valid_s1 <= in_valid;
			if (adv.s2) valid_s2 <= valid_s1;
			if (adv.s3) valid_s3 <= valid_s2;
			if (adv.s4) valid_s4 <= valid_s3;
			if (adv.s5) valid_s5 <= valid_s4;
			if (adv.s6) valid_s6 <= valid_s5;
		end
	end

	hsl_hue_unit u_hue (
		.clk       (clk),
		.adv       (adv),
		.hue       (hue),
		.k_s3      (k_s3),
		.sector_s3 (sector_s3)
	);

	hsl_chroma_unit u_chroma (
		.clk        (clk),
		.adv        (adv),
		.saturation (saturation),
		.lightness  (lightness),
		.cnum_s3    (cnum_s3),
		.lit_s3     (lit_s3)
	);

	hsl_mix_unit u_mix (
		.clk       (clk),
		.adv       (adv),
		.cnum_s3   (cnum_s3),
		.lit_s3    (lit_s3),
		.k_s3      (k_s3),
		.sector_s3 (sector_s3),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// Input backs up only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5
			&& valid_s6 && out_stall))
		else $error("input stalled with room in the pipeline");

	// A transfer in always lands in stage 1
	a_take_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted item lost at stage 1");

	// A held middle stage must sit behind a full, held stage
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !adv.s3) |-> (valid_s4 && !adv.s4))
		else $error("stage 3 held without a held stage 4");

	// A result that leaves is replaced only from stage 5
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s6 && !out_stall && !valid_s5) |=> !valid_s6)
		else $error("output valid without a source item");

endmodule

`default_nettype wire
